### hdl/ssd_pkg.sv
// Shared types, codes and segment tables for the seven-segment scan driver.
package ssd_pkg;

   localparam int VALUE_W = 14;
   localparam int MODE_W = 2;
   localparam int DIGEN_W = 4;
   localparam int SEG_W = 10;
   localparam int CODE_W = 4;
   localparam int NUM_DIGITS = 4;
   localparam int POS_W = 2;
   localparam int KIND_W = 2;

   localparam logic [MODE_W-1:0] MODE_DASHES = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DEGREES = 2'd1;
   localparam logic [MODE_W-1:0] MODE_CELSIUS = 2'd2;
   localparam logic [MODE_W-1:0] MODE_KEYS = 2'd3;

   localparam logic [KIND_W-1:0] KIND_BLANK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DASHES = 2'd1;
   localparam logic [KIND_W-1:0] KIND_SHOW = 2'd2;

   localparam logic [POS_W-1:0] POS_FIRST = 2'd0;
   localparam logic [POS_W-1:0] POS_SECOND = 2'd1;
   localparam logic [POS_W-1:0] POS_THIRD = 2'd2;

   localparam logic [CODE_W-1:0] CODE_C = 4'd10;
   localparam logic [VALUE_W-1:0] MAX_TENTHS = 14'd9999;
   localparam logic [VALUE_W-1:0] THRESHOLD_RESET = 14'd300;

   localparam logic [SEG_W-1:0] SEG_G = 10'h040;
   localparam logic [DIGEN_W-1:0] DIGEN_ALL = 4'hF;

   // reciprocal multipliers, exact for values up to 9999
   localparam int PROD_W = 28;
   localparam logic [PROD_W-1:0] RECIP_1000 = 28'd16778;
   localparam logic [PROD_W-1:0] RECIP_100 = 28'd10486;
   localparam logic [PROD_W-1:0] RECIP_10 = 28'd13108;

   typedef struct packed {
      logic [MODE_W-1:0] display_mode;
      logic [VALUE_W-1:0] value_tenths;
      logic [VALUE_W-1:0] temperature_tenths;
      logic blink_on;
   } req_type;

   typedef struct packed {
      logic [DIGEN_W-1:0] digit_enable;
      logic [SEG_W-1:0] segment_mask;
   } rsp_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [MODE_W-1:0] mode;
      logic [VALUE_W-1:0] value;
      logic [3:0] q1000;
      logic [6:0] q100;
      logic [9:0] q10;
   } front_stage_type;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [MODE_W-1:0] mode;
      logic [NUM_DIGITS-1:0][CODE_W-1:0] digits;
   } queue_entry_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] glyph(input logic [CODE_W-1:0] code);
      logic [6:0] seg;
      case (code)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         4'd10: seg = 7'h39;
         default: seg = 7'h00;
      endcase
      return seg;
   endfunction

endpackage

### hdl/seven_segment_scan_driver_core.sv
// Top level of the multiplexed four-digit seven-segment scan driver.
//
//   channel | prefix | direction | beat
//   --------+--------+-----------+-------------------------------------------
//   request | req_   | in        | one refresh tick: mode, value, temp, blink
//   result  | rsp_   | out       | digit enable and segment mask, one per tick
//   config  | csr_   | in        | alarm threshold in tenths, write only
//
// One tick per cycle sustained while rsp_stall stays low; a tick passes the front register
// (loaded at accept), then the queue, then the result register before it shows on rsp_.
// Synchronous reset clears the scan position, latched digits and threshold (300).
// A stall on rsp_ holds QUEUE_DEPTH + 2 beats (front register, queue, result
// register), then raises req_stall.
module seven_segment_scan_driver_core #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssd_pkg::rsp_type rsp_data,
   input  logic             csr_write_enable,
   input  logic [13:0]      csr_write_data
);
   import ssd_pkg::*;

   logic push;
   logic pop;
   queue_entry_type push_entry;
   queue_entry_type head_entry;
   queue_status_type queue_status;

   ssd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_data         (req_data),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .push             (push),
      .push_entry       (push_entry),
      .queue_status     (queue_status)
   );

   ssd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head_entry (head_entry),
      .status     (queue_status)
   );

   ssd_back u_back (
      .clock        (clock),
      .reset        (reset),
      .head_entry   (head_entry),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data)
   );

endmodule

### hdl/ssd_front.sv
// Front end: accept ticks, classify them and split the value into digits.
module ssd_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  ssd_pkg::req_type         req_data,
   input  logic                     csr_write_enable,
   input  logic [13:0]              csr_write_data,
   output logic                     push,
   output ssd_pkg::queue_entry_type push_entry,
   input  ssd_pkg::queue_status_type queue_status
);
   import ssd_pkg::*;

   logic [VALUE_W-1:0] threshold_ff, threshold_in;
   logic stage_valid_ff, stage_valid_in;
   front_stage_type stage_ff, stage_in;
   logic load;
   logic [VALUE_W-1:0] value_sat;
   logic [PROD_W-1:0] prod_1000, prod_100, prod_10;
   logic [6:0] d1_wide;
   logic [9:0] d2_wide;
   logic [VALUE_W-1:0] d3_wide;

   assign threshold_in = csr_write_enable ? csr_write_data : threshold_ff;

   assign push = stage_valid_ff && !queue_status.full;
   assign req_stall = stage_valid_ff && queue_status.full;
   assign load = req_valid && !req_stall;
   assign stage_valid_in = load || (stage_valid_ff && !push);

   always_comb begin
      value_sat = (req_data.value_tenths > MAX_TENTHS) ? MAX_TENTHS : req_data.value_tenths;
      prod_1000 = PROD_W'(value_sat) * RECIP_1000;
      prod_100 = PROD_W'(value_sat) * RECIP_100;
      prod_10 = PROD_W'(value_sat) * RECIP_10;
      stage_in.mode = req_data.display_mode;
      stage_in.value = value_sat;
      stage_in.q1000 = prod_1000[27:24];
      stage_in.q100 = prod_100[26:20];
      stage_in.q10 = prod_10[26:17];
      if ((req_data.temperature_tenths >= threshold_ff) && !req_data.blink_on) begin
         stage_in.kind = KIND_BLANK;
      end else if (req_data.display_mode == MODE_DASHES) begin
         stage_in.kind = KIND_DASHES;
      end else begin
         stage_in.kind = KIND_SHOW;
      end
   end

   always_comb begin
      d1_wide = stage_ff.q100 - ({3'b000, stage_ff.q1000} << 3)
              - ({3'b000, stage_ff.q1000} << 1);
      d2_wide = stage_ff.q10 - ({3'b000, stage_ff.q100} << 3)
              - ({3'b000, stage_ff.q100} << 1);
      d3_wide = stage_ff.value - ({4'b0000, stage_ff.q10} << 3)
              - ({4'b0000, stage_ff.q10} << 1);
      push_entry.kind = stage_ff.kind;
      push_entry.mode = stage_ff.mode;
      push_entry.digits[0] = stage_ff.q1000;
      push_entry.digits[1] = d1_wide[CODE_W-1:0];
      push_entry.digits[2] = d2_wide[CODE_W-1:0];
      push_entry.digits[3] = (stage_ff.mode == MODE_CELSIUS) ? CODE_C : d3_wide[CODE_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         stage_valid_ff <= 1'b0;
      end else begin
         threshold_ff <= threshold_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

endmodule

### hdl/ssd_queue.sv
// Small flip-flop queue between the front end and the scan back end.
module ssd_queue #(
   parameter int DEPTH = 4
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  ssd_pkg::queue_entry_type  push_entry,
   input  logic                      pop,
   output ssd_pkg::queue_entry_type  head_entry,
   output ssd_pkg::queue_status_type status
);
   import ssd_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   queue_entry_type entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign status.full = (count_ff == CNT_W'(DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_entry = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### hdl/ssd_back.sv
// Back end: scan position, digit latch, glyph lookup and result register.
module ssd_back (
   input  logic                      clock,
   input  logic                      reset,
   input  ssd_pkg::queue_entry_type  head_entry,
   input  ssd_pkg::queue_status_type queue_status,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output ssd_pkg::rsp_type          rsp_data
);
   import ssd_pkg::*;

   logic [POS_W-1:0] pos_ff, pos_in;
   logic [NUM_DIGITS-1:0][CODE_W-1:0] digits_ff, digits_in;
   logic rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff, rsp_data_in;
   logic [CODE_W-1:0] code;
   logic point;

   assign pop = !queue_status.empty && (!rsp_valid_ff || !rsp_stall);
   assign rsp_valid_in = pop || (rsp_valid_ff && rsp_stall);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

   always_comb begin
      pos_in = pos_ff;
      digits_in = digits_ff;
      code = (pos_ff == POS_FIRST) ? head_entry.digits[0] : digits_ff[pos_ff];
      point = ((head_entry.mode == MODE_DEGREES) && (pos_ff == POS_THIRD))
           || ((head_entry.mode == MODE_CELSIUS) && (pos_ff == POS_SECOND));
      rsp_data_in.digit_enable = '0;
      rsp_data_in.segment_mask = '0;
      case (head_entry.kind)
         KIND_DASHES: begin
            rsp_data_in.digit_enable = DIGEN_ALL;
            rsp_data_in.segment_mask = SEG_G;
         end
         KIND_SHOW: begin
            rsp_data_in.digit_enable = DIGEN_W'(1) << pos_ff;
            rsp_data_in.segment_mask = {2'b00, point, glyph(code)};
            if (pop) begin
               pos_in = pos_ff + 1'b1;
               if (pos_ff == POS_FIRST) begin
                  digits_in = head_entry.digits;
               end
            end
         end
         default: begin
            rsp_data_in.digit_enable = '0;
            rsp_data_in.segment_mask = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         digits_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff <= pos_in;
         digits_ff <= digits_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule

### hdl/ssd_checker.sv
// Port-level checks for the scan driver, bound to the top level.
module ssd_checker (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input ssd_pkg::rsp_type rsp_data
);
   import ssd_pkg::*;

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot(rsp_data.digit_enable) || (rsp_data.digit_enable == '0)
                     || (rsp_data.digit_enable == DIGEN_ALL)))
      else $error("digit enable is not blank, one-hot or all");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.digit_enable == '0)) |-> (rsp_data.segment_mask == '0))
      else $error("segments lit on a blank beat");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_data.digit_enable == DIGEN_ALL)) |-> (rsp_data.segment_mask == SEG_G))
      else $error("all digits enabled without a plain dash");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.segment_mask[9:8] == 2'b00))
      else $error("colon or upper dot lit");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat dropped or changed");

endmodule

bind seven_segment_scan_driver_core ssd_checker u_ssd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/tb_seven_segment_scan_driver_core.sv
// Self-checking testbench for the seven-segment scan driver core: random and directed ticks.
module tb_seven_segment_scan_driver_core;
   import ssd_pkg::*;

   localparam int IDLE_LIMIT = 3000;
   localparam int HOLD_CYCLES = 300;
   localparam int PRINT_CAP = 200;
   localparam int DOT_BIT = 7;
   localparam logic [13:0] THRESHOLD_TOP = 14'h3FFF;
   // segment patterns a..g for codes 0..15, code 0 in the low seven bits
   localparam logic [111:0] DIGIT_FONT = {35'h0, 7'h39, 7'h6F, 7'h7F, 7'h07, 7'h7D,
                                          7'h6D, 7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_write_enable = 1'b0;
   logic [13:0] csr_write_data = '0;

   req_type pending_ticks[$];
   rsp_type expected_scans[$];

   logic [13:0] alarm_threshold = THRESHOLD_RESET;
   logic [1:0] scan_pos = POS_FIRST;
   logic [3:0] digit_latch [NUM_DIGITS] = '{4'd0, 4'd0, 4'd0, 4'd0};

   int mismatch_count = 0;
   int idle_cycles = 0;
   bit tick_taken = 1'b0;
   int burst_left = 0;
   int gap_left = 0;
   int sender_gap_max = 0;
   bit hold_request = 1'b0;
   int hold_left = 0;
   logic [15:0] stall_pattern = '0;
   int pattern_age = 0;

   seven_segment_scan_driver_core DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data),
      .csr_write_enable(csr_write_enable),
      .csr_write_data(csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic rsp_type scan_tick(input req_type t);
      rsp_type r;
      logic [13:0] v;
      logic [9:0] seg;
      r = '0;
      if (t.temperature_tenths >= alarm_threshold && !t.blink_on) begin
         return r;
      end
      if (t.display_mode == MODE_DASHES) begin
         r.digit_enable = DIGEN_ALL;
         r.segment_mask = SEG_G;
         return r;
      end
      v = (t.value_tenths > MAX_TENTHS) ? MAX_TENTHS : t.value_tenths;
      if (scan_pos == POS_FIRST) begin
         digit_latch[0] = 4'(v / 1000);
         digit_latch[1] = 4'((v / 100) % 10);
         digit_latch[2] = 4'((v / 10) % 10);
         digit_latch[3] = (t.display_mode == MODE_CELSIUS) ? CODE_C : 4'(v % 10);
      end
      seg = {3'b000, DIGIT_FONT[digit_latch[scan_pos] * 7 +: 7]};
      if ((t.display_mode == MODE_DEGREES && scan_pos == POS_THIRD) ||
          (t.display_mode == MODE_CELSIUS && scan_pos == POS_SECOND)) begin
         seg[DOT_BIT] = 1'b1;
      end
      r.digit_enable = 4'b0001 << scan_pos;
      r.segment_mask = seg;
      scan_pos = scan_pos + 2'd1;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [13:0] got,
                                  input logic [13:0] want);
      if (mismatch_count < PRINT_CAP) begin
         $display("mismatch at %0t: %s got 'h%0h expected 'h%0h", $time, what, got, want);
      end
      mismatch_count++;
   endtask

   task automatic add_tick(input logic [1:0] mode, input logic [13:0] value,
                           input logic [13:0] temp, input logic blink);
      req_type t;
      t.display_mode = mode;
      t.value_tenths = value;
      t.temperature_tenths = temp;
      t.blink_on = blink;
      pending_ticks.push_back(t);
   endtask

   function automatic logic [13:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 14'($urandom_range(0, 99));
         1: return 14'($urandom_range(0, 9999));
         2: return 14'($urandom_range(0, 16383));
         3: return MAX_TENTHS;
         4: return 14'($urandom_range(10000, 16383));
         default: return 14'($urandom_range(9990, 10010));
      endcase
   endfunction

   function automatic logic [13:0] pick_temp(input logic [13:0] thr);
      case ($urandom_range(0, 4))
         0: return (thr == 0) ? 14'd0 : thr - 14'd1;
         1: return thr;
         2: return (thr == THRESHOLD_TOP) ? thr : thr + 14'd1;
         3: return 14'($urandom_range(0, 16383));
         default: return 14'($urandom_range(0, thr));
      endcase
   endfunction

   // one scan of four ticks sharing mode and value, with occasional disruption
   task automatic add_scan(input logic [13:0] thr);
      logic [1:0] mode;
      logic [13:0] value;
      mode = ($urandom_range(0, 7) == 0) ? MODE_DASHES : 2'($urandom_range(1, 3));
      value = pick_value();
      repeat (NUM_DIGITS) begin
         add_tick(($urandom_range(0, 5) == 0) ? 2'($urandom_range(0, 3)) : mode,
                  ($urandom_range(0, 5) == 0) ? pick_value() : value,
                  pick_temp(thr), 1'($urandom_range(0, 1)));
      end
   endtask

   task automatic wait_drained;
      while (pending_ticks.size() != 0 || expected_scans.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(negedge clock);
   endtask

   task automatic run_phase(input logic [13:0] thr, input int scans, input int gap_max,
                            input bit long_hold);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_write_data <= thr;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      alarm_threshold = thr;
      sender_gap_max = gap_max;
      @(posedge clock);
      if (long_hold) begin
         hold_request = 1'b1;
      end
      repeat (scans) add_scan(thr);
   endtask

   // driver: advance only after the current beat was taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || tick_taken) begin
         if (gap_left > 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (pending_ticks.size() != 0) begin
            req_valid <= 1'b1;
            req_data <= pending_ticks[0];
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(1, 24);
               gap_left = (sender_gap_max == 0 || $urandom_range(0, 2) == 0) ? 0 :
                          $urandom_range(1, sender_gap_max);
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // receiver: long hold on request, otherwise a rotating stall pattern
   always @(negedge clock) begin
      if (hold_request && hold_left == 0) begin
         hold_left = HOLD_CYCLES;
         hold_request = 1'b0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else begin
         if (pattern_age == 0) begin
            case ($urandom_range(0, 3))
               0: stall_pattern = '0;
               1: stall_pattern = 16'($urandom & $urandom);
               2: stall_pattern = 16'($urandom);
               default: stall_pattern = 16'($urandom | $urandom);
            endcase
            pattern_age = $urandom_range(16, 96);
         end else begin
            pattern_age--;
         end
         rsp_stall <= stall_pattern[0];
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   // monitor: check result beats, predict accepted ticks, watch for hangs
   always @(posedge clock) begin
      rsp_type want;
      bit rsp_taken;
      rsp_taken = !reset && rsp_valid && !rsp_stall;
      tick_taken = !reset && req_valid && !req_stall;
      if (rsp_taken) begin
         if (expected_scans.size() == 0) begin
            report_mismatch("beat with nothing expected", rsp_data, '0);
         end else begin
            want = expected_scans.pop_front();
            if (rsp_data.digit_enable !== want.digit_enable) begin
               report_mismatch("digit_enable", 14'(rsp_data.digit_enable),
                               14'(want.digit_enable));
            end
            if (rsp_data.segment_mask !== want.segment_mask) begin
               report_mismatch("segment_mask", 14'(rsp_data.segment_mask),
                               14'(want.segment_mask));
            end
         end
      end
      if (tick_taken) begin
         expected_scans.push_back(scan_tick(req_data));
         void'(pending_ticks.pop_front());
      end
      if (reset || rsp_taken || tick_taken) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("tb_seven_segment_scan_driver_core: FAIL");
            $finish;
         end
      end
   end

   initial begin
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(posedge clock);

      add_tick(MODE_DEGREES, 14'd1234, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd1234, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd1234, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd1234, 14'd0, 1'b1);
      add_tick(MODE_DASHES, 14'd5555, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd4321, 14'd300, 1'b0);
      add_tick(MODE_CELSIUS, 14'd9876, THRESHOLD_TOP, 1'b1);
      add_tick(MODE_CELSIUS, 14'd9876, THRESHOLD_TOP, 1'b1);
      add_tick(MODE_CELSIUS, 14'd9876, THRESHOLD_TOP, 1'b1);
      add_tick(MODE_CELSIUS, 14'd9876, THRESHOLD_TOP, 1'b1);
      add_tick(MODE_KEYS, 14'd1111, THRESHOLD_TOP, 1'b0);
      add_tick(MODE_KEYS, 14'h3FFF, 14'd299, 1'b0);
      add_tick(MODE_KEYS, 14'd0, 14'd299, 1'b0);
      add_tick(MODE_DEGREES, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_CELSIUS, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_KEYS, 14'd10000, 14'd0, 1'b0);
      add_tick(MODE_KEYS, 14'd10000, 14'd0, 1'b0);
      add_tick(MODE_KEYS, 14'd10000, 14'd0, 1'b0);
      add_tick(MODE_KEYS, 14'd10000, 14'd0, 1'b0);
      add_tick(MODE_DEGREES, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_DEGREES, 14'd0, 14'd0, 1'b1);
      add_tick(MODE_DASHES, 14'd0, 14'd0, 1'b0);
      add_tick(MODE_DEGREES, MAX_TENTHS, 14'd0, 1'b1);

      run_phase(14'd0, 38, 6, 1'b0);
      run_phase(THRESHOLD_TOP, 38, 0, 1'b1);
      run_phase(MAX_TENTHS, 50, 4, 1'b0);
      repeat (3) run_phase(14'($urandom_range(0, 9999)), 50, $urandom_range(0, 8), 1'b0);
      run_phase(THRESHOLD_RESET, 50, 3, 1'b0);

      wait_drained();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("tb_seven_segment_scan_driver_core: PASS");
      end else begin
         $display("tb_seven_segment_scan_driver_core: FAIL");
      end
      $finish;
   end

endmodule
